[design/srwm_pkg.sv]
package srwm_pkg;

   // Field widths
   localparam int FIELD_W   = 16;
   localparam int RATE_W    = 26;
   localparam int STATUS_W  = 2;

   // Samples per second from samples per millisecond
   localparam int SCALE     = 1000;
   localparam int SCALE_W   = 10;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_IN_BAND  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_BAND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

   // Register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_SPLIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_BAND_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_BAND_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_BAND_MIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_BAND_MAX  = 3'd5;

   localparam logic [RATE_W-1:0] RST_BAND_SPLIT    = 26'd40000;
   localparam logic [RATE_W-1:0] RST_HIGH_BAND_MIN = 26'd47000;
   localparam logic [RATE_W-1:0] RST_HIGH_BAND_MAX = 26'd49000;
   localparam logic [RATE_W-1:0] RST_LOW_BAND_MIN  = 26'd7000;
   localparam logic [RATE_W-1:0] RST_LOW_BAND_MAX  = 26'd9000;

   typedef struct packed {
      logic [FIELD_W-1:0] sample_count;
      logic [FIELD_W-1:0] interval_ms;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RATE_W-1:0]   rate;
   } rsp_type;

   typedef struct packed {
      logic              enable;
      logic [RATE_W-1:0] band_split;
      logic [RATE_W-1:0] high_band_min;
      logic [RATE_W-1:0] high_band_max;
      logic [RATE_W-1:0] low_band_min;
      logic [RATE_W-1:0] low_band_max;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load_in;
      logic set_invalid;
      logic update;
      logic mul;
      logic div_step;
      logic set_rate;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_zero;
      logic check_due;
      logic div_last;
   } sts_type;

endpackage

[design/sample_rate_window_monitor.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  srwm_pkg::req_type (sample_count, interval_ms)
// rsp       out        rsp_valid / rsp_stall  srwm_pkg::rsp_type (status, rate)
// csr       in         psel/penable/pready    6 registers at byte address 4*i
//
// Invalid report: acceptance sets the result and moves to emit; input free once
// the result is out. Window fill only: input free after the update state. Check:
// update, multiply, then a restoring divide of the NUM_W-bit numerator, one bit
// a cycle, NUM_W = 16 + clog2(WINDOW_DEPTH) + 10 (30 at depth 16); then compare
// and emit. Synchronous reset clears the sums, write slot and pending result and
// resets the registers. A stalled result blocks the next; the input waits behind it.
module sample_rate_window_monitor #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  srwm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output srwm_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [srwm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [srwm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [srwm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int RATE_W = srwm_pkg::RATE_W;
   localparam int DATA_W = srwm_pkg::CSR_DATA_W;

   srwm_pkg::cfg_type cfg_ff;
   srwm_pkg::cfg_type cfg_in;
   srwm_pkg::cmd_type cmd;
   srwm_pkg::sts_type sts;

   logic [srwm_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                           csr_write;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[srwm_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   // Register write decode, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_idx)
            srwm_pkg::REG_ENABLE:        cfg_in.enable        = pwdata[0];
            srwm_pkg::REG_BAND_SPLIT:    cfg_in.band_split    = pwdata[RATE_W-1:0];
            srwm_pkg::REG_HIGH_BAND_MIN: cfg_in.high_band_min = pwdata[RATE_W-1:0];
            srwm_pkg::REG_HIGH_BAND_MAX: cfg_in.high_band_max = pwdata[RATE_W-1:0];
            srwm_pkg::REG_LOW_BAND_MIN:  cfg_in.low_band_min  = pwdata[RATE_W-1:0];
            srwm_pkg::REG_LOW_BAND_MAX:  cfg_in.low_band_max  = pwdata[RATE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.band_split    <= srwm_pkg::RST_BAND_SPLIT;
         cfg_ff.high_band_min <= srwm_pkg::RST_HIGH_BAND_MIN;
         cfg_ff.high_band_max <= srwm_pkg::RST_HIGH_BAND_MAX;
         cfg_ff.low_band_min  <= srwm_pkg::RST_LOW_BAND_MIN;
         cfg_ff.low_band_max  <= srwm_pkg::RST_LOW_BAND_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read back
   always_comb begin
      case (csr_idx)
         srwm_pkg::REG_ENABLE:        prdata = DATA_W'(cfg_ff.enable);
         srwm_pkg::REG_BAND_SPLIT:    prdata = DATA_W'(cfg_ff.band_split);
         srwm_pkg::REG_HIGH_BAND_MIN: prdata = DATA_W'(cfg_ff.high_band_min);
         srwm_pkg::REG_HIGH_BAND_MAX: prdata = DATA_W'(cfg_ff.high_band_max);
         srwm_pkg::REG_LOW_BAND_MIN:  prdata = DATA_W'(cfg_ff.low_band_min);
         srwm_pkg::REG_LOW_BAND_MAX:  prdata = DATA_W'(cfg_ff.low_band_max);
         default:                     prdata = '0;
      endcase
   end

   srwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .enable    (cfg_ff.enable),
      .sts       (sts),
      .cmd       (cmd)
   );

   srwm_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

[design/srwm_ram.sv]
module srwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/srwm_ctrl.sv]
module srwm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic             enable,
   input  srwm_pkg::sts_type sts,
   output srwm_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_CMP    = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_accept;
   logic       out_free;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Sequence one transaction: invalid report, or window update with divide and compare when a check is due
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && enable) begin
               cmd.load_in = 1'b1;
               if (sts.in_zero) begin
                  cmd.set_invalid = 1'b1;
                  state_in        = S_EMIT;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = sts.check_due ? S_MUL : S_IDLE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.set_rate = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until the far side takes it
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/srwm_dp.sv]
module srwm_dp #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  srwm_pkg::req_type req_data,
   input  srwm_pkg::cfg_type cfg,
   input  srwm_pkg::cmd_type cmd,
   output srwm_pkg::sts_type sts,
   output srwm_pkg::rsp_type rsp_data
);

   localparam int FIELD_W   = srwm_pkg::FIELD_W;
   localparam int RATE_W    = srwm_pkg::RATE_W;
   localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
   localparam int SUM_W     = FIELD_W + SLOT_W;
   localparam int NUM_W     = SUM_W + srwm_pkg::SCALE_W;
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int MEM_W     = 2 * FIELD_W;

   localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
   localparam logic [DIV_CNT_W-1:0] LAST_BIT  = DIV_CNT_W'(NUM_W - 1);

   srwm_pkg::req_type in_ff;
   srwm_pkg::rsp_type result_ff;
   srwm_pkg::rsp_type result_in;
   srwm_pkg::rsp_type rsp_data_ff;

   // The write slot also counts reports since the last check: both advance
   // together and wrap at the window depth.
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    slot_in;
   logic                 full_ff;
   logic                 full_in;
   logic [SUM_W-1:0]     count_sum_ff;
   logic [SUM_W-1:0]     count_sum_in;
   logic [SUM_W-1:0]     interval_sum_ff;
   logic [SUM_W-1:0]     interval_sum_in;
   logic [MEM_W-1:0]     rd_data;
   logic [FIELD_W-1:0]   old_count;
   logic [FIELD_W-1:0]   old_interval;

   logic [SUM_W-1:0]     rem_ff;
   logic [SUM_W-1:0]     rem_in;
   logic [NUM_W-1:0]     quo_ff;
   logic [NUM_W-1:0]     quo_in;
   logic [SUM_W-1:0]     divisor_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DIV_CNT_W-1:0] div_cnt_in;
   logic [SUM_W:0]       rem_shift;
   logic [SUM_W:0]       trial;
   logic                 fits;

   logic [RATE_W-1:0]    rate;
   logic                 use_high;
   logic [RATE_W-1:0]    band_lo;
   logic [RATE_W-1:0]    band_hi;

   // Window store: count in the upper half, interval in the lower half
   srwm_ram #(
      .WIDTH (MEM_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff),
      .wr_data ({in_ff.sample_count, in_ff.interval_ms}),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // Slots not yet written since reset read as zero
   assign old_count    = full_ff ? rd_data[MEM_W-1:FIELD_W] : '0;
   assign old_interval = full_ff ? rd_data[FIELD_W-1:0] : '0;

   // Swap the oldest pair out of the running sums
   assign count_sum_in    = count_sum_ff - SUM_W'(old_count) + SUM_W'(in_ff.sample_count);
   assign interval_sum_in = interval_sum_ff - SUM_W'(old_interval)
                            + SUM_W'(in_ff.interval_ms);
   assign slot_in         = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
   assign full_in         = full_ff || (slot_ff == LAST_SLOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff         <= '0;
         full_ff         <= 1'b0;
         count_sum_ff    <= '0;
         interval_sum_ff <= '0;
      end else if (cmd.update) begin
         slot_ff         <= slot_in;
         full_ff         <= full_in;
         count_sum_ff    <= count_sum_in;
         interval_sum_ff <= interval_sum_in;
      end
   end

   // Latch the transaction
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_data;
      end
   end

   // Restoring divider, one quotient bit a cycle
   assign rem_shift  = {rem_ff, quo_ff[NUM_W-1]};
   assign trial      = rem_shift - {1'b0, divisor_ff};
   assign fits       = !trial[SUM_W];
   assign rem_in     = fits ? trial[SUM_W-1:0] : rem_shift[SUM_W-1:0];
   assign quo_in     = {quo_ff[NUM_W-2:0], fits};
   assign div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         quo_ff     <= NUM_W'(count_sum_ff) * NUM_W'(srwm_pkg::SCALE);
         rem_ff     <= '0;
         divisor_ff <= interval_sum_ff;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff     <= quo_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Pick the band and classify the rate
   assign rate     = (divisor_ff == '0) ? '0 : quo_ff[RATE_W-1:0];
   assign use_high = rate > cfg.band_split;
   assign band_lo  = use_high ? cfg.high_band_min : cfg.low_band_min;
   assign band_hi  = use_high ? cfg.high_band_max : cfg.low_band_max;

   always_comb begin
      result_in = result_ff;
      if (cmd.set_invalid) begin
         result_in.status = srwm_pkg::STATUS_INVALID;
         result_in.rate   = '0;
      end else if (cmd.set_rate) begin
         result_in.status = (rate < band_lo || rate > band_hi) ?
                            srwm_pkg::STATUS_OUT_BAND : srwm_pkg::STATUS_IN_BAND;
         result_in.rate   = rate;
      end
   end

   // Result and output registers
   always_ff @(posedge clock) begin
      result_ff <= result_in;
      if (cmd.emit) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

   // Status to the controller
   assign sts.in_zero   = (req_data.sample_count == '0) || (req_data.interval_ms == '0);
   assign sts.check_due = (slot_ff == LAST_SLOT);
   assign sts.div_last  = (div_cnt_ff == LAST_BIT);

endmodule

[design/srwm_checker.sv]
module srwm_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input srwm_pkg::rsp_type rsp_data,
   input logic              pready
);

   // A stalled transaction stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // An invalid report carries a zero rate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == srwm_pkg::STATUS_INVALID |-> rsp_data.rate == '0)
      else $error("invalid result with nonzero rate");

   // Reset leaves no result pending and the register port ready
   assert property (@(posedge clock)
      reset |=> !rsp_valid && pready)
      else $error("result pending after reset");

endmodule

bind sample_rate_window_monitor srwm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .pready    (pready)
);
